@@ rtl/assert_macros.svh @@
// assertion macros shared by the frame reorder buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FRB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame reorder buffer check failed");

// next-cycle implication, checked out of reset
`define FRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame reorder buffer check failed");

`endif

@@ rtl/frb_pkg.sv @@
// types and constants of the frame reorder buffer
package frb_pkg;

  localparam int DEPTH       = 64;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int IDX_W   = 32;
  localparam int HDL_W   = 16;
  localparam int BYTES_W = 24;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;
  localparam int CFG_W   = 7;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_PEEK = 2'd1,
    OP_DEL  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_LATE  = 3'd1,
    ST_DUP   = 3'd2,
    ST_EMPTY = 3'd3,
    ST_ZERO  = 3'd4
  } status_t;

  typedef enum logic {
    REG_REORDER  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                   valid;
    logic [IDX_W-1:0]       index;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                   ins;
    logic                   del;
    logic                   clr;
    logic                   reorder;
    logic [IDX_W-1:0]       idx;
    logic [HANDLE_BITS-1:0] hdl;
  } ctrl_t;

endpackage

@@ rtl/frb_if.sv @@
// handshake channels of the frame reorder buffer

interface frb_in_if;
  frb_pkg::op_t                        op;
  logic [frb_pkg::IDX_W-1:0]           frame_index;
  logic [frb_pkg::HDL_W-1:0]           frame_handle;
  logic [frb_pkg::BYTES_W-1:0]         frame_bytes;
  logic                                valid;
  logic                                ready;

  modport source (output op, frame_index, frame_handle, frame_bytes, valid, input ready);
  modport sink   (input op, frame_index, frame_handle, frame_bytes, valid, output ready);
endinterface

interface frb_out_if;
  frb_pkg::status_t                    status;
  logic                                flushed;
  logic [frb_pkg::IDX_W-1:0]           head_index;
  logic [frb_pkg::HDL_W-1:0]           head_handle;
  logic [frb_pkg::COUNT_W-1:0]         entry_count;
  logic                                valid;
  logic                                ready;

  modport source (output status, flushed, head_index, head_handle, entry_count, valid,
                  input ready);
  modport sink   (input status, flushed, head_index, head_handle, entry_count, valid,
                  output ready);
endinterface

interface frb_cfg_if;
  frb_pkg::reg_idx_t                   index;
  logic [frb_pkg::CFG_W-1:0]           data;
  logic                                valid;
  logic                                ready;

  modport source (output index, data, valid, input ready);
  modport sink   (input index, data, valid, output ready);
endinterface

@@ rtl/frame_reorder_buffer_core.sv @@
// frame reorder buffer: chain of entry slots, sorted by index in reorder mode, with a registered result
// the result beat of an accepted beat is registered and is offered in the next cycle
// throughput: one beat per cycle while results are taken; every slot compares and shifts at once
// a result beat that waits untaken holds the input side off until it is taken
// reset (rst, synchronous): buffer empty, next index zero, reorder on, capacity 64
module frame_reorder_buffer_core (
  input logic clk,
  input logic rst,
  frb_in_if.sink    item,
  frb_out_if.source result,
  frb_cfg_if.sink   cfg
);
  import frb_pkg::*;
  `include "assert_macros.svh"

  logic             reorder_en;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] held;
  logic [IDX_W-1:0] next_idx;

  logic             res_valid;
  status_t          res_status;
  logic             res_flushed;
  logic [IDX_W-1:0] res_index;
  logic [HDL_W-1:0] res_handle;
  logic [CNT_W-1:0] res_count;

  ctrl_t            ctrl;
  entry_t           head;
  logic             dup_hit;

  logic             acc, push, peek, del, full, flush, late, dup, zero, has_any;
  logic [31:0]      cap_eff;
  logic [CNT_W-1:0] held_next;
  logic [IDX_W-1:0] next_idx_next;
  status_t          status_next;

  assign item.ready = ~res_valid | result.ready;
  assign cfg.ready  = 1'b1;
  assign acc        = item.valid & item.ready;

  always_comb begin
    cap_eff = (32'(capacity) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(capacity);
    full    = 32'(held) >= cap_eff;
    push    = acc & (item.op == OP_PUSH);
    flush   = push & full;
    has_any = ~flush & (held != '0);
    zero    = item.frame_bytes == '0;
    late    = reorder_en & has_any & (item.frame_index < next_idx);
    dup     = reorder_en & has_any & dup_hit;
    peek    = acc & (item.op == OP_PEEK) & (held != '0);
    del     = acc & (item.op == OP_DEL) & (held != '0);

    ctrl.ins     = push & ~zero & ~late & ~dup;
    ctrl.del     = del;
    ctrl.clr     = flush;
    ctrl.reorder = reorder_en;
    ctrl.idx     = item.frame_index;
    ctrl.hdl     = HANDLE_BITS'(item.frame_handle);
  end

  always_comb begin
    held_next     = flush ? '0 : held;
    next_idx_next = next_idx;
    status_next   = ST_OK;
    case (item.op)
      OP_PUSH: begin
        if (zero) begin
          status_next = ST_ZERO;
        end else if (late) begin
          status_next = ST_LATE;
        end else if (dup) begin
          status_next = ST_DUP;
        end else begin
          held_next = held_next + 1'b1;
        end
      end
      OP_PEEK: begin
        if (held == '0) begin
          status_next = ST_EMPTY;
        end else if (reorder_en) begin
          next_idx_next = head.index + 1'b1;
        end
      end
      OP_DEL: begin
        if (held == '0) begin
          status_next = ST_EMPTY;
        end else begin
          held_next = held - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  frb_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .head    (head),
    .dup_hit (dup_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reorder_en <= 1'b1;
      capacity   <= CAPACITY_RESET;
      held       <= '0;
      next_idx   <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_REORDER:  reorder_en <= cfg.data[0];
          REG_CAPACITY: capacity   <= cfg.data[CAP_W-1:0];
          default:      reorder_en <= reorder_en;
        endcase
      end
      if (acc) begin
        held     <= held_next;
        next_idx <= next_idx_next;
      end
      if (acc) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (acc) begin
      res_status  <= status_next;
      res_flushed <= flush;
      res_index   <= peek ? head.index : '0;
      res_handle  <= peek ? HDL_W'(head.handle) : '0;
      res_count   <= held_next;
    end
  end

  assign result.valid       = res_valid;
  assign result.status      = res_status;
  assign result.flushed     = res_flushed;
  assign result.head_index  = res_index;
  assign result.head_handle = res_handle;
  assign result.entry_count = COUNT_W'(res_count);

  `FRB_ASSERT_NOW(a_count_bound, 1'b1, 32'(held) <= 32'(DEPTH))
  `FRB_ASSERT_NOW(a_empty_count, res_valid && res_status == ST_EMPTY, res_count == '0)
  `FRB_ASSERT_NOW(a_late_no_flush, res_valid && res_status == ST_LATE, !res_flushed)
  `FRB_ASSERT_NEXT(a_delete_shrinks, del, held == $past(held) - 1'b1)

endmodule

@@ rtl/frb_cell.sv @@
// one slot of the sorted entry chain
module frb_cell (
  input  logic           clk,
  input  logic           rst,
  input  frb_pkg::ctrl_t ctrl,
  input  frb_pkg::entry_t left,
  input  logic           left_ahead,
  input  frb_pkg::entry_t right,
  output frb_pkg::entry_t ent,
  output logic           ahead,
  output logic           hit
);
  import frb_pkg::*;

  logic                   valid;
  logic [IDX_W-1:0]       index;
  logic [HANDLE_BITS-1:0] handle;

  logic                   valid_next;
  logic [IDX_W-1:0]       index_next;
  logic [HANDLE_BITS-1:0] handle_next;
  logic                   load;
  logic                   v;

  always_comb begin
    v     = valid & ~ctrl.clr;
    // slot stays ahead of the new frame only while every slot to its left does
    // (fifo: every held slot)
    ahead = left_ahead & v & (~ctrl.reorder | (index <= ctrl.idx));
    hit   = ahead & (index == ctrl.idx);
    ent   = '{valid: v, index: index, handle: handle};
  end

  always_comb begin
    valid_next  = v;
    load        = 1'b0;
    index_next  = right.index;
    handle_next = right.handle;
    if (ctrl.ins) begin
      valid_next = v | left.valid;
      if (!ahead) begin
        load = 1'b1;
        if (left_ahead) begin
          index_next  = ctrl.idx;
          handle_next = ctrl.hdl;
        end else begin
          index_next  = left.index;
          handle_next = left.handle;
        end
      end
    end else if (ctrl.del) begin
      load       = 1'b1;
      valid_next = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    if (load) begin
      index  <= index_next;
      handle <= handle_next;
    end
  end

endmodule

@@ rtl/frb_chain.sv @@
// row of entry slots, head at slot zero
module frb_chain (
  input  logic            clk,
  input  logic            rst,
  input  frb_pkg::ctrl_t  ctrl,
  output frb_pkg::entry_t head,
  output logic            dup_hit
);
  import frb_pkg::*;

  entry_t           ents   [DEPTH];
  logic             aheads [DEPTH];
  logic [DEPTH-1:0] hits;

  localparam entry_t EDGE_LEFT  = '{valid: 1'b1, index: '0, handle: '0};
  localparam entry_t EDGE_RIGHT = '{valid: 1'b0, index: '0, handle: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t lft;
    entry_t rgt;
    logic   lft_ahead;

    if (i == 0) begin : g_first
      assign lft       = EDGE_LEFT;
      assign lft_ahead = 1'b1;
    end else begin : g_mid
      assign lft       = ents[i-1];
      assign lft_ahead = aheads[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rgt = EDGE_RIGHT;
    end else begin : g_inner
      assign rgt = ents[i+1];
    end

    frb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left       (lft),
      .left_ahead (lft_ahead),
      .right      (rgt),
      .ent        (ents[i]),
      .ahead      (aheads[i]),
      .hit        (hits[i])
    );
  end

  assign head    = ents[0];
  assign dup_hit = |hits;

endmodule

@@ bench/testbench.sv @@
// testbench of the frame reorder buffer: directed and random beats checked against a table model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import frb_pkg::*;

  typedef struct {
    status_t          status;
    logic             flushed;
    logic [IDX_W-1:0] head_index;
    logic [HDL_W-1:0] head_handle;
    logic [COUNT_W-1:0] entry_count;
  } frame_result_t;

  // table model of the buffer and the queue of results it predicts
  class frame_table_model;
    bit                     reorder_on;
    logic [CAP_W-1:0]       cap_reg;
    logic [IDX_W-1:0]       idx_tab [DEPTH];
    logic [HANDLE_BITS-1:0] hdl_tab [DEPTH];
    int unsigned            held;
    logic [IDX_W-1:0]       next_idx;
    frame_result_t          expected_q [$];
    int                     errors;
    int                     n_items;
    int                     n_checked;
    int                     n_flush;
    int                     n_dropped;

    function new();
      reorder_on = 1'b1;
      cap_reg    = CAPACITY_RESET;
      held       = 0;
      next_idx   = '0;
      errors     = 0;
      n_items    = 0;
      n_checked  = 0;
      n_flush    = 0;
      n_dropped  = 0;
    endfunction

    function void write_reg(reg_idx_t ri, logic [CFG_W-1:0] val);
      if (ri == REG_REORDER) begin
        reorder_on = val[0];
      end else begin
        cap_reg = val[CAP_W-1:0];
      end
    endfunction

    function void insert_at(int unsigned pos, logic [IDX_W-1:0] idx,
                            logic [HANDLE_BITS-1:0] hdl);
      for (int unsigned i = held; i > pos; i--) begin
        idx_tab[i] = idx_tab[i-1];
        hdl_tab[i] = hdl_tab[i-1];
      end
      idx_tab[pos] = idx;
      hdl_tab[pos] = hdl;
      held++;
    endfunction

    function void note_item(op_t op, logic [IDX_W-1:0] idx, logic [HDL_W-1:0] hdl,
                            logic [BYTES_W-1:0] nbytes);
      frame_result_t r;
      int unsigned   eff_cap;
      int unsigned   p;
      bit            dup;
      r.status      = ST_OK;
      r.flushed     = 1'b0;
      r.head_index  = '0;
      r.head_handle = '0;
      n_items++;
      case (op)
        OP_PUSH: begin
          eff_cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
          if (held >= eff_cap) begin
            held = 0;
            r.flushed = 1'b1;
            n_flush++;
          end
          if (nbytes == '0) begin
            r.status = ST_ZERO;
          end else if (!reorder_on || held == 0) begin
            insert_at(held, idx, hdl[HANDLE_BITS-1:0]);
          end else if (idx < next_idx) begin
            r.status = ST_LATE;
            n_dropped++;
          end else begin
            p   = 0;
            dup = 1'b0;
            while (p < held && idx_tab[p] <= idx) begin
              if (idx_tab[p] == idx) dup = 1'b1;
              p++;
            end
            if (dup) begin
              r.status = ST_DUP;
              n_dropped++;
            end else begin
              insert_at(p, idx, hdl[HANDLE_BITS-1:0]);
            end
          end
        end
        OP_PEEK: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.head_index  = idx_tab[0];
            r.head_handle = HDL_W'(hdl_tab[0]);
            if (reorder_on) next_idx = idx_tab[0] + 1'b1;
          end
        end
        OP_DEL: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (int unsigned i = 0; i + 1 < held; i++) begin
              idx_tab[i] = idx_tab[i+1];
              hdl_tab[i] = hdl_tab[i+1];
            end
            held--;
          end
        end
        default: ;
      endcase
      r.entry_count = COUNT_W'(held);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(status_t st, logic fl, logic [IDX_W-1:0] hi,
                               logic [HDL_W-1:0] hh, logic [COUNT_W-1:0] cnt);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t ns: result beat with none expected, expected nothing, actual status %0h",
                 $time, st);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        compare_field("status", 32'(e.status), 32'(st));
        compare_field("flushed", 32'(e.flushed), 32'(fl));
        compare_field("head_index", e.head_index, hi);
        compare_field("head_handle", 32'(e.head_handle), 32'(hh));
        compare_field("entry_count", 32'(e.entry_count), 32'(cnt));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  frb_in_if  item_ch ();
  frb_out_if res_ch ();
  frb_cfg_if cfg_ch ();

  frame_reorder_buffer_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  frame_table_model sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[frame_reorder_buffer_core] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // note accepted beats before checking, so a same-edge result still finds its entry
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        sb.note_item(item_ch.op, item_ch.frame_index, item_ch.frame_handle,
                     item_ch.frame_bytes);
      end
      if (res_ch.valid && res_ch.ready) begin
        sb.check_result(res_ch.status, res_ch.flushed, res_ch.head_index,
                        res_ch.head_handle, res_ch.entry_count);
      end
    end
  end

  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [HDL_W-1:0] hdl,
                           logic [BYTES_W-1:0] nbytes);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.op           <= op;
    item_ch.frame_index  <= idx;
    item_ch.frame_handle <= hdl;
    item_ch.frame_bytes  <= nbytes;
    item_ch.valid        <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t ri, logic [CFG_W-1:0] val);
    cfg_ch.index <= ri;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(ri, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(bit reorder, logic [CAP_W-1:0] cap);
    drain();
    write_reg(REG_REORDER, CFG_W'(reorder));
    write_reg(REG_CAPACITY, cap);
    n_settings++;
  endtask

  task automatic random_item(int push_pct);
    logic [IDX_W-1:0]   idx;
    logic [BYTES_W-1:0] nbytes;
    int                 k;
    int                 q;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < push_pct) begin
      // mostly jitter just ahead of the consume point, some duplicates and late frames
      if (k < 60) begin
        idx = sb.next_idx + $urandom_range(0, 95);
      end else if (k < 72 && sb.held > 0) begin
        idx = sb.idx_tab[$urandom_range(0, sb.held - 1)];
      end else if (k < 84) begin
        idx = sb.next_idx - $urandom_range(1, 8);
      end else begin
        idx = $urandom;
      end
      q = $urandom_range(0, 99);
      if (q < 6) nbytes = '0;
      else if (q < 10) nbytes = '1;
      else nbytes = BYTES_W'($urandom_range(1, 24'hFFFFFF));
      send_item(OP_PUSH, idx, HDL_W'($urandom), nbytes);
    end else begin
      q = $urandom_range(0, 99);
      idx = $urandom;
      if (q < 45) send_item(OP_PEEK, idx, HDL_W'($urandom), BYTES_W'($urandom));
      else if (q < 93) send_item(OP_DEL, idx, HDL_W'($urandom), BYTES_W'($urandom));
      else send_item(OP_NOP, idx, HDL_W'($urandom), BYTES_W'($urandom));
    end
  endtask

  typedef struct {
    bit               reorder;
    logic [CAP_W-1:0] cap;
    int               push_pct;
  } seg_cfg_t;

  seg_cfg_t segs [10] = '{
    '{1'b1, 7'd64, 85}, '{1'b1, 7'd4, 55}, '{1'b0, 7'd64, 85}, '{1'b1, 7'd1, 50},
    '{1'b0, 7'd3, 55}, '{1'b1, 7'd0, 50}, '{1'b1, 7'd127, 80}, '{1'b0, 7'd16, 60},
    '{1'b1, 7'd8, 60}, '{1'b1, 7'd100, 85}
  };

  initial begin
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.op           <= OP_NOP;
    item_ch.frame_index  <= '0;
    item_ch.frame_handle <= '0;
    item_ch.frame_bytes  <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_REORDER;
    cfg_ch.data          <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reorder mode from reset: empty table, sorting, drops, wrap of the next index
    send_item(OP_PEEK, '0, '0, '0);
    send_item(OP_DEL, '0, '0, '0);
    send_item(OP_NOP, '1, '1, '1);
    send_item(OP_PUSH, 32'd10, 16'hFFFF, 24'hFFFFFF);
    send_item(OP_PUSH, 32'd5, 16'h0001, 24'h000001);
    send_item(OP_PUSH, 32'd10, 16'h1234, 24'h000010);
    send_item(OP_PUSH, 32'd7, 16'h2222, 24'h000000);
    send_item(OP_PEEK, '0, '0, '0);
    send_item(OP_PUSH, 32'd3, 16'h3333, 24'h000100);
    send_item(OP_DEL, '0, '0, '0);
    send_item(OP_PEEK, '0, '0, '0);
    send_item(OP_DEL, '0, '0, '0);
    // older than the consume point but the table is empty, so it is kept
    send_item(OP_PUSH, 32'd2, 16'h4444, 24'h000200);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 16'h0000, 24'h800000);
    send_item(OP_DEL, '0, '0, '0);
    send_item(OP_PEEK, '0, '0, '0);
    send_item(OP_PUSH, 32'd0, 16'h5A5A, 24'h000001);
    send_item(OP_PUSH, 32'h8000_0000, 16'hA5A5, 24'h7FFFFF);

    // fifo mode appends out of order
    reconfigure(1'b0, 7'd64);
    send_item(OP_PUSH, 32'd9, 16'h0009, 24'h000009);
    send_item(OP_PUSH, 32'd4, 16'h0004, 24'h000004);
    send_item(OP_PEEK, '0, '0, '0);
    // capacity below the entries held: next push flushes
    reconfigure(1'b0, 7'd2);
    send_item(OP_PUSH, 32'd20, 16'h0020, 24'h000020);
    reconfigure(1'b1, 7'd1);
    send_item(OP_PUSH, 32'd30, 16'h0030, 24'h000030);
    send_item(OP_PUSH, 32'd31, 16'h0031, 24'h000000);
    reconfigure(1'b1, 7'd0);
    send_item(OP_PUSH, 32'd40, 16'h0040, 24'h000040);
    send_item(OP_PUSH, 32'd41, 16'h0041, 24'h000041);

    for (int s = 0; s < 10; s++) begin
      reconfigure(segs[s].reorder, segs[s].cap);
      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < 110; n++) begin
        if (n == 55 && s == 4) drain();
        random_item(segs[s].push_pct);
      end
    end

    item_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (16) @(posedge clk);

    $display("run covered %0d beats over %0d register settings and four idle patterns",
             sb.n_items, n_settings);
    $display("%0d results checked, %0d flushes, %0d late or duplicate drops",
             sb.n_checked, sb.n_flush, sb.n_dropped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[frame_reorder_buffer_core] OK");
    end else begin
      $display("[frame_reorder_buffer_core] ERROR");
    end
    $finish;
  end

endmodule
